// ----- rtl/uki_pkg.sv -----
package uki_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned AtanMax  = 24;

  // Start vector of the rotation, 0.6072529350 in Q1.30
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  // round(2^23 / pi): radians to binary angle, scaled by 2^8
  localparam logic [21:0] RadToBam = 22'd2670177;

  localparam logic [31:0] AtanTab [AtanMax] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_SPEED  = 3'd0,
    REG_MAX_RATE   = 3'd1,
    REG_MAX_ACCEL  = 3'd2,
    REG_TIME_STEP  = 3'd3,
    REG_START_X    = 3'd4,
    REG_START_Y    = 3'd5,
    REG_START_HEAD = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_STEP    = 1'b0,
    OP_RESTART = 1'b1
  } opcode_e;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] throttle;
    logic signed [15:0] steering;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [23:0] speed;
  } out_item_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_TGT, MUL_LIM, MUL_RATE, MUL_P1, MUL_PH, MUL_PL, MUL_DS, MUL_DX, MUL_DY
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TGT, ST_LIM, ST_RATE, ST_SPD, ST_P1, ST_PH, ST_PL, ST_YAW,
    ST_CINIT, ST_CORD, ST_DS, ST_DX, ST_DY, ST_PY, ST_DONE
  } state_e;

  typedef struct packed {
    logic     restart;
    mul_sel_e mul_sel;
    logic     cap_tgt;
    logic     cap_lim;
    logic     cap_rate;
    logic     upd_speed;
    logic     cap_pl;
    logic     cap_acc;
    logic     upd_yaw;
    logic     cord_init;
    logic     cord_step;
    logic     cap_ds;
    logic     upd_x;
    logic     upd_y;
    logic     load_out;
  } uki_cmd_t;

  typedef struct packed {
    logic restart_req;
    logic cord_last;
  } uki_status_t;

endpackage

// ----- rtl/unicycle_kinematic_integrator.sv -----
// Unicycle dead-reckoning integrator.
// Input channel (in_valid_i/in_ready_o/in_data_i): one command per transfer,
// either an integrate step (throttle, steering) or a restart to the start pose.
// Output channel (out_valid_o/out_ready_i/out_data_o): one pose per command,
// in command order.
// Config channel (cfg_*): register index and data; always ready. Write only
// while idle. Unknown indexes are ignored.
// Timing: a restart result skips the computation and goes straight to the
// final step; a step result waits for the shared 26x33 multiplier sequence
// and the one-iteration-per-cycle rotation.
// One command is in flight at a time; the next is taken once the result is
// in the output register, while that result still waits for the receiver.
// A stalled receiver holds the block in its final step until the output
// register frees, so no result is lost.
// Reset: configuration returns to defaults, pose is zero, speed zero.
module unicycle_kinematic_integrator #(
  parameter int unsigned ANGLE_ITERATIONS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [uki_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [uki_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  uki_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output uki_pkg::out_item_t           out_data_o
);
  import uki_pkg::*;

  uki_cmd_t    cmd;
  uki_status_t status;
  logic        in_xfer;

  // registers take a write in any cycle
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i & in_ready_o;

  uki_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  uki_datapath #(
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .in_load_i   (in_xfer),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/uki_ctrl.sv -----
module uki_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  uki_pkg::uki_status_t status_i,
  output uki_pkg::uki_cmd_t    cmd_o
);
  import uki_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer, out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_xfer) state_d = status_i.restart_req ? ST_DONE : ST_TGT;
      ST_TGT:   state_d = ST_LIM;
      ST_LIM:   state_d = ST_RATE;
      ST_RATE:  state_d = ST_SPD;
      ST_SPD:   state_d = ST_P1;
      ST_P1:    state_d = ST_PH;
      ST_PH:    state_d = ST_PL;
      ST_PL:    state_d = ST_YAW;
      ST_YAW:   state_d = ST_CINIT;
      ST_CINIT: state_d = ST_CORD;
      ST_CORD:  if (status_i.cord_last) state_d = ST_DS;
      ST_DS:    state_d = ST_DX;
      ST_DX:    state_d = ST_DY;
      ST_DY:    state_d = ST_PY;
      ST_PY:    state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_NONE;
    unique case (state_q)
      ST_IDLE:  cmd_o.restart = in_xfer & status_i.restart_req;
      ST_TGT:   cmd_o.mul_sel = MUL_TGT;
      ST_LIM: begin
        cmd_o.cap_tgt = 1'b1;
        cmd_o.mul_sel = MUL_LIM;
      end
      ST_RATE: begin
        cmd_o.cap_lim = 1'b1;
        cmd_o.mul_sel = MUL_RATE;
      end
      ST_SPD: begin
        cmd_o.cap_rate  = 1'b1;
        cmd_o.upd_speed = 1'b1;
      end
      ST_P1:    cmd_o.mul_sel = MUL_P1;
      ST_PH: begin
        cmd_o.cap_pl  = 1'b1;
        cmd_o.mul_sel = MUL_PH;
      end
      ST_PL: begin
        cmd_o.cap_acc = 1'b1;
        cmd_o.mul_sel = MUL_PL;
      end
      ST_YAW:   cmd_o.upd_yaw = 1'b1;
      ST_CINIT: begin
        cmd_o.cord_init = 1'b1;
        cmd_o.mul_sel   = MUL_DS;
      end
      ST_CORD:  cmd_o.cord_step = 1'b1;
      ST_DS:    cmd_o.cap_ds = 1'b1;
      ST_DX:    cmd_o.mul_sel = MUL_DX;
      ST_DY: begin
        cmd_o.upd_x   = 1'b1;
        cmd_o.mul_sel = MUL_DY;
      end
      ST_PY:    cmd_o.upd_y = 1'b1;
      ST_DONE:  cmd_o.load_out = out_free;
      default:  cmd_o.mul_sel = MUL_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a pending result is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("result lost while stalled");

  // no new result overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && out_valid_q && !out_ready_i |=> state_q == ST_DONE)
    else $error("left done while output stalled");

  // rotation is always entered through its setup step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORD) |-> ($past(state_q) == ST_CINIT || $past(state_q) == ST_CORD))
    else $error("rotation without setup");

endmodule

// ----- rtl/uki_datapath.sv -----
module uki_datapath #(
  parameter int unsigned ANGLE_ITERATIONS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uki_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [uki_pkg::CfgDataW-1:0]   cfg_data_i,
  input  uki_pkg::in_item_t              in_data_i,
  input  logic                           in_load_i,
  input  uki_pkg::uki_cmd_t              cmd_i,
  output uki_pkg::uki_status_t           status_o,
  output uki_pkg::out_item_t             out_data_o
);
  import uki_pkg::*;

  localparam int unsigned NIter = (ANGLE_ITERATIONS > AtanMax) ? AtanMax : ANGLE_ITERATIONS;

  // configuration
  logic [22:0] mls_q, ma_q;
  logic [19:0] mar_q;
  logic [15:0] dt_q;
  logic signed [31:0] sx_q, sy_q;
  logic signed [15:0] sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mls_q <= 23'd65536;
      mar_q <= 20'd65536;
      ma_q  <= 23'd65536;
      dt_q  <= 16'd6554;
      sx_q  <= '0;
      sy_q  <= '0;
      sh_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAX_SPEED:  mls_q <= cfg_data_i[22:0];
        REG_MAX_RATE:   mar_q <= cfg_data_i[19:0];
        REG_MAX_ACCEL:  ma_q  <= cfg_data_i[22:0];
        REG_TIME_STEP:  dt_q  <= cfg_data_i[15:0];
        REG_START_X:    sx_q  <= cfg_data_i;
        REG_START_Y:    sy_q  <= cfg_data_i[31:0];
        REG_START_HEAD: sh_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // latched command
  logic signed [15:0] thr_q, str_q;
  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      thr_q <= in_data_i.throttle;
      str_q <= in_data_i.steering;
    end
  end
  assign status_o.restart_req = (in_data_i.opcode == OP_RESTART);

  // shared multiplier
  logic signed [25:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [58:0] mul_p, prod_q;
  logic signed [21:0] rate_q;
  logic [15:0] pl_q;
  logic signed [24:0] ds_q;
  logic signed [32:0] cos_q, sin_q;
  logic signed [23:0] speed_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_TGT: begin
        mul_a = {{10{thr_q[15]}}, thr_q};
        mul_b = {10'b0, mls_q};
      end
      MUL_LIM: begin
        mul_a = {10'b0, dt_q};
        mul_b = {10'b0, ma_q};
      end
      MUL_RATE: begin
        mul_a = {{10{str_q[15]}}, str_q};
        mul_b = {13'b0, mar_q};
      end
      MUL_P1: begin
        mul_a = {{4{rate_q[21]}}, rate_q};
        mul_b = {17'b0, dt_q};
      end
      MUL_PH: begin
        mul_a = {{4{prod_q[37]}}, prod_q[37:16]};
        mul_b = {11'b0, RadToBam};
      end
      MUL_PL: begin
        mul_a = {10'b0, pl_q};
        mul_b = {11'b0, RadToBam};
      end
      MUL_DS: begin
        mul_a = {{2{speed_q[23]}}, speed_q};
        mul_b = {17'b0, dt_q};
      end
      MUL_DX: begin
        mul_a = {ds_q[24], ds_q};
        mul_b = cos_q;
      end
      MUL_DY: begin
        mul_a = {ds_q[24], ds_q};
        mul_b = sin_q;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sel != MUL_NONE) prod_q <= mul_p;
  end

  // rounded views of the product, ties toward plus infinity
  logic signed [58:0] r15, r16, r30;
  assign r15 = (prod_q + 59'sd16384) >>> 15;
  assign r16 = (prod_q + 59'sd32768) >>> 16;
  assign r30 = (prod_q + 59'sd536870912) >>> 30;

  // speed slew
  logic signed [25:0] target_q;
  logic [23:0] limit_q;
  logic signed [26:0] delta, delta_c, lim_s, spd_sum;
  logic signed [23:0] speed_sat;

  always_comb begin
    lim_s   = {3'b0, limit_q};
    delta   = {target_q[25], target_q} - {{3{speed_q[23]}}, speed_q};
    delta_c = delta;
    if (delta > lim_s) delta_c = lim_s;
    if (delta < -lim_s) delta_c = -lim_s;
    spd_sum = {{3{speed_q[23]}}, speed_q} + delta_c;
    if (spd_sum > 27'sd8388607) speed_sat = 24'sh7FFFFF;
    else if (spd_sum < -27'sd8388608) speed_sat = 24'sh800000;
    else speed_sat = spd_sum[23:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_tgt)  target_q <= r15[25:0];
    if (cmd_i.cap_lim)  limit_q  <= r16[23:0];
    if (cmd_i.cap_rate) rate_q   <= r15[21:0];
    if (cmd_i.cap_pl)   pl_q     <= prod_q[15:0];
  end

  // heading step: (rate*dt) * RadToBam / 2^40, split at bit 16 of rate*dt
  logic signed [59:0] acc_q, ysum;
  logic signed [15:0] yaw_q;
  assign ysum = acc_q + {prod_q[58], prod_q} + (60'sd1 <<< 39);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_acc) acc_q <= {prod_q[43:0], 16'b0};
  end

  // rotation
  logic signed [33:0] cx_q, cy_q, xs, ys, cxn, cyn;
  logic signed [32:0] cz_q, at;
  logic flip_q;
  logic [4:0] iter_q;
  logic [31:0] ang;

  assign ang = {yaw_q, 16'b0};
  assign xs  = cx_q >>> iter_q;
  assign ys  = cy_q >>> iter_q;
  assign at  = {1'b0, AtanTab[iter_q]};
  assign cxn = flip_q ? -cx_q : cx_q;
  assign cyn = flip_q ? -cy_q : cy_q;
  assign status_o.cord_last = (iter_q == 5'(NIter - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cord_init) begin
      flip_q <= ang[31] ^ ang[30];
      cz_q   <= {ang[30], ang[30], ang[30:0]};
      cx_q   <= CordicGain;
      cy_q   <= '0;
      iter_q <= '0;
    end else if (cmd_i.cord_step) begin
      if (!cz_q[32]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end
      iter_q <= iter_q + 5'd1;
    end
    if (cmd_i.cap_ds) begin
      ds_q  <= r16[24:0];
      cos_q <= cxn[32:0];
      sin_q <= cyn[32:0];
    end
  end

  // position, saturating
  logic signed [31:0] east_q, north_q;
  logic signed [33:0] pos_sum, pos_base;
  logic signed [31:0] pos_sat;

  always_comb begin
    pos_base = cmd_i.upd_x ? {{2{east_q[31]}}, east_q} : {{2{north_q[31]}}, north_q};
    pos_sum  = pos_base + r30[33:0];
    if (pos_sum > 34'sd2147483647) pos_sat = 32'sh7FFFFFFF;
    else if (pos_sum < -34'sd2147483648) pos_sat = 32'sh80000000;
    else pos_sat = pos_sum[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      east_q  <= '0;
      north_q <= '0;
      yaw_q   <= '0;
      speed_q <= '0;
    end else if (cmd_i.restart) begin
      east_q  <= sx_q;
      north_q <= sy_q;
      yaw_q   <= sh_q;
      speed_q <= '0;
    end else begin
      if (cmd_i.upd_speed) speed_q <= speed_sat;
      if (cmd_i.upd_yaw)   yaw_q   <= yaw_q + ysum[55:40];
      if (cmd_i.upd_x)     east_q  <= pos_sat;
      if (cmd_i.upd_y)     north_q <= pos_sat;
    end
  end

  out_item_t out_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.pos_x   <= east_q;
      out_q.pos_y   <= north_q;
      out_q.heading <= yaw_q;
      out_q.speed   <= speed_q;
    end
  end
  assign out_data_o = out_q;

endmodule
